// ===== src/mmst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmst_pkg
// shared types, constants and helpers of the scaled transposed matrix multiply
// ----------------------------------------------------------------------------
package mmst_pkg;

  localparam int MAX_DIM  = 8;
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int DIM_W    = 4;
  localparam int ELEM_W   = 16;
  localparam int ALPHA_W  = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int ACC_W    = PROD_W + IDX_W;
  localparam int RES_W    = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SPLIT_W  = 16;
  localparam int FRAC_W   = 8;

  // operation codes
  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_COLUMNS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_A    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_B    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA          = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_DRAIN,
    ST_WAIT
  } mmst_state_e;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } mmst_meta_t;

  // last index of a size register: zero acts as one, large values clamp
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
    logic [IDX_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(d - DIM_W'(1));
    end
    return r;
  endfunction

endpackage

// ===== src/mmst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmst_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mmst_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/mmst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmst_cell
// one accumulator cell of the rotating partial sum chain
// ----------------------------------------------------------------------------
module mmst_cell
  import mmst_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     add_en_i,
  input  logic signed [ACC_W-1:0]  sum_i,
  input  logic signed [PROD_W-1:0] prod_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [ACC_W-1:0] acc_d, acc_q;

  // neighbor sum plus product when this cell closes the loop
  always_comb begin
    acc_d = sum_i + (add_en_i ? ACC_W'(prod_i) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== src/mmst_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmst_scale
// alpha scaling, floor shift and saturation with output register
// ----------------------------------------------------------------------------
module mmst_scale
  import mmst_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      launch_i,
  input  logic signed [ACC_W-1:0]   acc_i,
  input  logic signed [ALPHA_W-1:0] alpha_i,
  input  mmst_meta_t                meta_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic signed [RES_W-1:0]   result_o,
  output mmst_meta_t                meta_o
);

  localparam int HI_W  = ACC_W - SPLIT_W;
  localparam int PHI_W = HI_W + ALPHA_W;
  localparam int PLO_W = SPLIT_W + 1 + ALPHA_W;
  localparam int TOT_W = PHI_W + SPLIT_W;
  localparam int SH_W  = TOT_W - FRAC_W;

  logic                    s1_v_q;
  logic signed [PHI_W-1:0] p_hi_d, p_hi_q;
  logic signed [PLO_W-1:0] p_lo_d, p_lo_q;
  mmst_meta_t              s1_meta_q;
  logic signed [TOT_W-1:0] total;
  logic signed [SH_W-1:0]  shifted;
  logic signed [RES_W-1:0] sat;
  logic                    out_valid_q;
  logic signed [RES_W-1:0] result_q;
  mmst_meta_t              meta_q;

  // accumulator split in two halves so each product stays narrow
  always_comb begin
    p_hi_d = $signed(acc_i[ACC_W-1:SPLIT_W]) * alpha_i;
    p_lo_d = $signed({1'b0, acc_i[SPLIT_W-1:0]}) * alpha_i;
  end

  always_comb begin
    total   = $signed({p_hi_q, {SPLIT_W{1'b0}}}) + TOT_W'(p_lo_q);
    shifted = total[TOT_W-1:FRAC_W];
    if (&shifted[SH_W-1:RES_W-1] || ~|shifted[SH_W-1:RES_W-1]) begin
      sat = shifted[RES_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sat = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(RES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q <= launch_i;
      if (s1_v_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch_i) begin
      p_hi_q    <= p_hi_d;
      p_lo_q    <= p_lo_d;
      s1_meta_q <= meta_i;
    end
    if (s1_v_q) begin
      result_q <= sat;
      meta_q   <= s1_meta_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign meta_o      = meta_q;

endmodule

// ===== src/matrix_multiply_scaled_transposed_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_scaled_transposed_unit
// C = alpha * op(A) * op(B) in Q8.8 / Q16.16 fixed point, chain of accumulators
// ----------------------------------------------------------------------------
// loads of A or B elements are accepted back to back while idle
// a compute request holds input stalled until its last result is taken and the chain has drained
// per result row: a mac sweep of all chain slots for each inner step, a flush of
//   the read and multiply stages, then a drain of 8 chain steps, each emitted element held until the output takes it
// reset clears control and the accumulator chain and presets configuration; the A and B
//   stores are undefined until written, no clearing pass
// ----------------------------------------------------------------------------
module matrix_multiply_scaled_transposed_unit
  import mmst_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic [IDX_W-1:0]          row_i,
  input  logic [IDX_W-1:0]          column_i,
  input  logic signed [ELEM_W-1:0]  value_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [RES_W-1:0]   result_value_o,
  output logic [IDX_W-1:0]          result_row_o,
  output logic [IDX_W-1:0]          result_column_o,
  output logic                      last_o
);

  // configuration registers
  logic [DIM_W-1:0]          result_rows_q, inner_size_q, result_columns_q;
  logic                      transpose_a_q, transpose_b_q;
  logic signed [ALPHA_W-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_rows_q    <= DIM_W'(1);
      inner_size_q     <= DIM_W'(1);
      result_columns_q <= DIM_W'(1);
      transpose_a_q    <= 1'b0;
      transpose_b_q    <= 1'b0;
      alpha_q          <= ALPHA_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RESULT_ROWS:    result_rows_q    <= cfg_data_i[DIM_W-1:0];
        CFG_INNER_SIZE:     inner_size_q     <= cfg_data_i[DIM_W-1:0];
        CFG_RESULT_COLUMNS: result_columns_q <= cfg_data_i[DIM_W-1:0];
        CFG_TRANSPOSE_A:    transpose_a_q    <= cfg_data_i[0];
        CFG_TRANSPOSE_B:    transpose_b_q    <= cfg_data_i[0];
        CFG_ALPHA:          alpha_q          <= $signed(cfg_data_i[ALPHA_W-1:0]);
        default: ;
      endcase
    end
  end

  // effective last indexes of the three dimensions
  logic [IDX_W-1:0] m_last, n_last, p_last;
  assign m_last = dim_last(result_rows_q);
  assign n_last = dim_last(inner_size_q);
  assign p_last = dim_last(result_columns_q);

  localparam logic [IDX_W-1:0] COL_END = IDX_W'(MAX_DIM - 1);

  mmst_state_e       state_q, state_d;
  logic [IDX_W-1:0]  row_q, k_q, col_q;
  logic              rd_v_q, prod_v_q;
  logic signed [PROD_W-1:0] prod_q;

  logic in_accept, start, issue, drain_shift, launch, row_end, out_fire;

  assign in_accept = in_valid_i && !in_stall_o;
  assign start     = in_accept && (operation_i == OP_COMPUTE);
  assign out_fire  = out_valid_o && !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_MAC;
      end
      ST_MAC: begin
        // last column of last inner step issued
        if (col_q == COL_END && k_q == n_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        // wait for read and multiply stages to empty into the chain
        if (!rd_v_q && !prod_v_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (col_q <= p_last) begin
          state_d = ST_WAIT;
        end else if (col_q == COL_END) begin
          state_d = (row_q == m_last) ? ST_IDLE : ST_MAC;
        end
      end
      ST_WAIT: begin
        if (out_fire) begin
          // column counter already wrapped means the whole chain went out
          if (col_q == '0) begin
            state_d = (row_q == m_last) ? ST_IDLE : ST_MAC;
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    issue       = (state_q == ST_MAC);
    drain_shift = (state_q == ST_DRAIN);
    launch      = (state_q == ST_DRAIN) && (col_q <= p_last);
    row_end     = ((state_q == ST_DRAIN) && (col_q > p_last) && (col_q == COL_END)) ||
                  ((state_q == ST_WAIT) && out_fire && (col_q == '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      row_q    <= '0;
      k_q      <= '0;
      col_q    <= '0;
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= issue;
      prod_v_q <= rd_v_q;
      if (start) begin
        row_q <= '0;
        k_q   <= '0;
        col_q <= '0;
      end
      // column walks all chain slots, inner index steps once per sweep
      if (issue) begin
        col_q <= col_q + IDX_W'(1);
        if (col_q == COL_END) begin
          k_q <= (k_q == n_last) ? '0 : k_q + IDX_W'(1);
        end
      end
      if (drain_shift) begin
        col_q <= col_q + IDX_W'(1);
      end
      if (row_end) begin
        row_q <= (row_q == m_last) ? '0 : row_q + IDX_W'(1);
      end
    end
  end

  // element stores, transpose handled by swapping the address halves
  logic [ADDR_W-1:0] a_raddr, b_raddr, waddr;
  logic [ELEM_W-1:0] a_rdata, b_rdata;
  logic              we_a, we_b;

  assign waddr   = {row_i, column_i};
  assign we_a    = in_accept && (operation_i == OP_LOAD_A);
  assign we_b    = in_accept && (operation_i == OP_LOAD_B);
  assign a_raddr = transpose_a_q ? {k_q, row_q} : {row_q, k_q};
  assign b_raddr = transpose_b_q ? {col_q, k_q} : {k_q, col_q};

  mmst_ram #(.Width(ELEM_W), .Depth(DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mmst_ram #(.Width(ELEM_W), .Depth(DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // product stage
  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_q <= $signed(a_rdata) * $signed(b_rdata);
    end
  end

  // rotating chain of column accumulators: slot 0 feeds the tail, which adds
  // the incoming product; during drain the tail takes zero to clear the row
  logic signed [ACC_W-1:0] chain [MAX_DIM];
  logic signed [ACC_W-1:0] tail_sum;
  logic                    chain_en;

  assign chain_en = prod_v_q || drain_shift;
  assign tail_sum = drain_shift ? '0 : chain[0];

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    if (c == MAX_DIM - 1) begin : g_tail
      mmst_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (chain_en),
        .add_en_i (prod_v_q),
        .sum_i    (tail_sum),
        .prod_i   (prod_q),
        .acc_o    (chain[c])
      );
    end else begin : g_body
      mmst_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (chain_en),
        .add_en_i (1'b0),
        .sum_i    (chain[c+1]),
        .prod_i   (prod_q),
        .acc_o    (chain[c])
      );
    end
  end

  // scaling and output register
  mmst_meta_t launch_meta, out_meta;

  always_comb begin
    launch_meta.row  = row_q;
    launch_meta.col  = col_q;
    launch_meta.last = (row_q == m_last) && (col_q == p_last);
  end

  mmst_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .launch_i    (launch),
    .acc_i       (chain[0]),
    .alpha_i     (alpha_q),
    .meta_i      (launch_meta),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result_value_o),
    .meta_o      (out_meta)
  );

  assign result_row_o    = out_meta.row;
  assign result_column_o = out_meta.col;
  assign last_o          = out_meta.last;

  // a result only waits while the sequencer is parked for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == ST_WAIT))
    else $error("result valid outside wait state");

  // products only reach the chain during accumulation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_v_q |-> (state_q == ST_MAC || state_q == ST_FLUSH))
    else $error("product arrived outside accumulation");

  // drain never overlaps a product still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (!rd_v_q && !prod_v_q))
    else $error("drain started with pipeline busy");

  // a compute request leaves the idle state on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q == ST_MAC))
    else $error("compute request not started");

endmodule
